// ----- rtl/core/qoa_pkg.sv -----
`default_nettype none

package qoa_pkg;

    // Stream framing
    localparam int SAMPLES_PER_SLICE = 20;
    localparam int CNT_W         = $clog2(SAMPLES_PER_SLICE + 1);
    localparam int WORD_BYTES    = 8;
    localparam int MIN_FRAME     = 24;
    localparam int CODE_BITS     = 60;

    // Command queue between front and LMS engine
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Sample arithmetic
    localparam int PRED_SHIFT = 13;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = PROD_W + 2;
    localparam int PRED_W     = ACC_W - PRED_SHIFT;
    localparam int SUM_W      = PRED_W + 1;

    typedef enum logic [1:0] {
        CMD_HIST  = 2'd0,
        CMD_WGT   = 2'd1,
        CMD_SLICE = 2'd2,
        CMD_ERR   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [63:0]        data;
        logic [CNT_W-1:0]   count;
        logic               stream_last;
    } cmd_t;

    // Dequantized residual for a scale index and a 3-bit code
    function automatic logic signed [15:0] qoa_dequant(input logic [3:0] sf,
                                                       input logic [2:0] qc);
        logic [63:0] row;
        logic [15:0] mag;
        case (sf)
            4'd0:    row = {16'd1,    16'd3,    16'd5,    16'd7};
            4'd1:    row = {16'd5,    16'd18,   16'd32,   16'd49};
            4'd2:    row = {16'd16,   16'd53,   16'd95,   16'd147};
            4'd3:    row = {16'd34,   16'd113,  16'd203,  16'd315};
            4'd4:    row = {16'd63,   16'd210,  16'd378,  16'd588};
            4'd5:    row = {16'd104,  16'd345,  16'd621,  16'd966};
            4'd6:    row = {16'd158,  16'd528,  16'd950,  16'd1477};
            4'd7:    row = {16'd228,  16'd760,  16'd1368, 16'd2128};
            4'd8:    row = {16'd316,  16'd1053, 16'd1895, 16'd2947};
            4'd9:    row = {16'd422,  16'd1405, 16'd2529, 16'd3934};
            4'd10:   row = {16'd548,  16'd1828, 16'd3290, 16'd5117};
            4'd11:   row = {16'd696,  16'd2320, 16'd4176, 16'd6496};
            4'd12:   row = {16'd868,  16'd2893, 16'd5207, 16'd8099};
            4'd13:   row = {16'd1064, 16'd3548, 16'd6386, 16'd9933};
            4'd14:   row = {16'd1286, 16'd4288, 16'd7718, 16'd12005};
            default: row = {16'd1536, 16'd5120, 16'd9216, 16'd14336};
        endcase
        case (qc[2:1])
            2'd0:    mag = row[63:48];
            2'd1:    mag = row[47:32];
            2'd2:    mag = row[31:16];
            default: mag = row[15:0];
        endcase
        return qc[0] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qoa_cmd_fifo.sv -----
`default_nettype none

module qoa_cmd_fifo
    import qoa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    cmd_t                  mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/qoa_front.sv -----
`default_nettype none

module qoa_front
    import qoa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [63:0] stream_word,
    input  wire logic        first_word,
    input  wire logic        word_valid,
    output logic             word_ready,
    input  wire logic [31:0] sample_total,
    input  wire logic        cmd_full,
    output logic             cmd_push,
    output cmd_t             cmd_data
);

    typedef enum logic [5:0] {
        F_HEADER  = 6'b000001,
        F_HISTORY = 6'b000010,
        F_WEIGHTS = 6'b000100,
        F_SLICE   = 6'b001000,
        F_PAD     = 6'b010000,
        F_STOPPED = 6'b100000
    } front_state_t;

    front_state_t phase_reg, phase_next;
    logic [15:0]  fsr_reg, fsr_next;
    logic [15:0]  fbr_reg, fbr_next;
    logic [31:0]  ssr_reg, ssr_next;

    // Working copies after an optional restart
    front_state_t     ph;
    logic [15:0]      fsr;
    logic [15:0]      fbr;
    logic [31:0]      ssr;
    logic [15:0]      fbr_eat;
    logic [CNT_W-1:0] n;
    logic [15:0]      hdr_fs;
    logic [15:0]      hdr_fz;
    logic             hdr_bad;
    logic             accept;

    assign word_ready = !cmd_full;
    assign accept     = word_valid && !cmd_full;

    // Classify the word and build the request for the engine
    always_comb
    begin
        phase_next = phase_reg;
        fsr_next   = fsr_reg;
        fbr_next   = fbr_reg;
        ssr_next   = ssr_reg;
        cmd_push   = 1'b0;
        cmd_data   = '{kind: CMD_HIST, data: stream_word, count: '0, stream_last: 1'b0};

        ph  = phase_reg;
        fsr = fsr_reg;
        fbr = fbr_reg;
        ssr = ssr_reg;
        if (first_word)
        begin
            ph  = F_HEADER;
            fsr = '0;
            fbr = '0;
            ssr = sample_total;
        end

        fbr_eat = (fbr > 16'(WORD_BYTES)) ? fbr - 16'(WORD_BYTES) : '0;
        n       = (fsr < 16'(SAMPLES_PER_SLICE)) ? fsr[CNT_W-1:0] : CNT_W'(SAMPLES_PER_SLICE);
        hdr_fs  = stream_word[31:16];
        hdr_fz  = stream_word[15:0];
        hdr_bad = (stream_word[63:56] != 8'd1) || (hdr_fs == '0)
                  || (hdr_fz < 16'(MIN_FRAME));

        if (accept)
        begin
            phase_next = ph;
            fsr_next   = fsr;
            fbr_next   = fbr;
            ssr_next   = ssr;
            if (ph != F_STOPPED && ssr != '0)
            begin
                case (ph)
                    F_HEADER:
                    begin
                        if (hdr_bad)
                        begin
                            phase_next    = F_STOPPED;
                            cmd_push      = 1'b1;
                            cmd_data.kind = CMD_ERR;
                        end
                        else
                        begin
                            fsr_next   = ({16'd0, hdr_fs} > ssr) ? ssr[15:0] : hdr_fs;
                            fbr_next   = hdr_fz - 16'(WORD_BYTES);
                            phase_next = F_HISTORY;
                        end
                    end
                    F_HISTORY:
                    begin
                        cmd_push      = 1'b1;
                        cmd_data.kind = CMD_HIST;
                        fbr_next      = fbr_eat;
                        phase_next    = F_WEIGHTS;
                    end
                    F_WEIGHTS:
                    begin
                        cmd_push      = 1'b1;
                        cmd_data.kind = CMD_WGT;
                        fbr_next      = fbr_eat;
                        phase_next    = F_SLICE;
                    end
                    F_SLICE:
                    begin
                        cmd_push             = 1'b1;
                        cmd_data.kind        = CMD_SLICE;
                        cmd_data.count       = n;
                        cmd_data.stream_last = (ssr == 32'(n));
                        fbr_next             = fbr_eat;
                        fsr_next             = fsr - 16'(n);
                        ssr_next             = ssr - 32'(n);
                        if (fsr == 16'(n))
                        begin
                            phase_next = (fbr_eat != '0) ? F_PAD : F_HEADER;
                        end
                    end
                    F_PAD:
                    begin
                        fbr_next = fbr_eat;
                        if (fbr_eat == '0)
                        begin
                            phase_next = F_HEADER;
                        end
                    end
                    default:
                    begin
                        phase_next = ph;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= F_HEADER;
            fsr_reg   <= '0;
            fbr_reg   <= '0;
            ssr_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fsr_reg   <= fsr_next;
            fbr_reg   <= fbr_next;
            ssr_reg   <= ssr_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/qoa_lms_engine.sv -----
`default_nettype none

module qoa_lms_engine
    import qoa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_empty,
    input  wire cmd_t         cmd_data,
    output logic              cmd_pop,
    output logic              sample_valid,
    input  wire logic         sample_ready,
    output logic signed [15:0] pcm_sample,
    output logic              last_of_slice,
    output logic              stream_end,
    output logic              format_error
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MUL  = 3'b010,
        B_ACC  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic signed [15:0] hist_reg [4];
    logic signed [15:0] hist_next [4];
    logic signed [15:0] wgt_reg [4];
    logic signed [15:0] wgt_next [4];

    logic [CNT_W-1:0]     left_reg, left_next;
    logic                 end_flag_reg, end_flag_next;
    logic [3:0]           scale_reg, scale_next;
    logic [CODE_BITS-1:0] codes_reg, codes_next;
    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [PROD_W-1:0] prod_next [4];
    logic signed [15:0]   r_reg, r_next;

    logic                 sample_valid_reg, sample_valid_next;
    logic signed [15:0]   pcm_reg, pcm_next;
    logic                 last_reg, last_next;
    logic                 end_reg, end_next;
    logic                 err_reg, err_next;

    logic                     out_free;
    logic signed [ACC_W-1:0]  acc;
    logic signed [PRED_W-1:0] pred;
    logic signed [SUM_W-1:0]  s_wide;
    logic signed [15:0]       s_sat;
    logic signed [15:0]       delta;
    logic                     slice_done;

    assign sample_valid  = sample_valid_reg;
    assign pcm_sample    = pcm_reg;
    assign last_of_slice = last_reg;
    assign stream_end    = end_reg;
    assign format_error  = err_reg;

    assign out_free = !sample_valid_reg || sample_ready;

    // Prediction, saturation and sign-data weight step
    always_comb
    begin
        acc = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1])
            + ACC_W'(prod_reg[2]) + ACC_W'(prod_reg[3]);
        pred   = acc[ACC_W-1:PRED_SHIFT];
        s_wide = SUM_W'(pred) + SUM_W'(r_reg);
        if (s_wide > SUM_W'(32767))
        begin
            s_sat = 16'sh7fff;
        end
        else if (s_wide < -SUM_W'(32768))
        begin
            s_sat = -16'sh8000;
        end
        else
        begin
            s_sat = s_wide[15:0];
        end
        delta      = r_reg >>> 4;
        slice_done = (left_reg == CNT_W'(1));
    end

    // Sequence commands and samples
    always_comb
    begin
        state_next        = state_reg;
        hist_next         = hist_reg;
        wgt_next          = wgt_reg;
        left_next         = left_reg;
        end_flag_next     = end_flag_reg;
        scale_next        = scale_reg;
        codes_next        = codes_reg;
        prod_next         = prod_reg;
        r_next            = r_reg;
        sample_valid_next = sample_valid_reg && !sample_ready;
        pcm_next          = pcm_reg;
        last_next         = last_reg;
        end_next          = end_reg;
        err_next          = err_reg;
        cmd_pop           = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty && (cmd_data.kind != CMD_ERR || out_free))
                begin
                    cmd_pop = 1'b1;
                    case (cmd_data.kind)
                        CMD_HIST:
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                hist_next[k] = cmd_data.data[48-16*k +: 16];
                            end
                        end
                        CMD_WGT:
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                wgt_next[k] = cmd_data.data[48-16*k +: 16];
                            end
                        end
                        CMD_SLICE:
                        begin
                            scale_next    = cmd_data.data[63:60];
                            codes_next    = cmd_data.data[CODE_BITS-1:0];
                            left_next     = cmd_data.count;
                            end_flag_next = cmd_data.stream_last;
                            state_next    = B_MUL;
                        end
                        default:
                        begin
                            sample_valid_next = 1'b1;
                            pcm_next          = '0;
                            last_next         = 1'b1;
                            end_next          = 1'b0;
                            err_next          = 1'b1;
                        end
                    endcase
                end
            end
            B_MUL:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    prod_next[k] = wgt_reg[k] * hist_reg[k];
                end
                r_next     = qoa_dequant(scale_reg, codes_reg[CODE_BITS-1 -: 3]);
                codes_next = codes_reg << 3;
                state_next = B_ACC;
            end
            B_ACC:
            begin
                if (out_free)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        wgt_next[k] = hist_reg[k][15] ? wgt_reg[k] - delta
                                                      : wgt_reg[k] + delta;
                    end
                    hist_next[0]      = hist_reg[1];
                    hist_next[1]      = hist_reg[2];
                    hist_next[2]      = hist_reg[3];
                    hist_next[3]      = s_sat;
                    sample_valid_next = 1'b1;
                    pcm_next          = s_sat;
                    last_next         = slice_done;
                    end_next          = slice_done && end_flag_reg;
                    err_next          = 1'b0;
                    left_next         = left_reg - 1'b1;
                    state_next        = slice_done ? B_IDLE : B_MUL;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            sample_valid_reg <= 1'b0;
            left_reg         <= '0;
            end_flag_reg     <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                hist_reg[k] <= '0;
                wgt_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            sample_valid_reg <= sample_valid_next;
            left_reg         <= left_next;
            end_flag_reg     <= end_flag_next;
            hist_reg         <= hist_next;
            wgt_reg          <= wgt_next;
        end
    end

    // Hold datapath and result payload
    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
        codes_reg <= codes_next;
        prod_reg  <= prod_next;
        r_reg     <= r_next;
        pcm_reg   <= pcm_next;
        last_reg  <= last_next;
        end_reg   <= end_next;
        err_reg   <= err_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/qoa_mono_stream_decoder.sv -----
`default_nettype none

// Mono QOA stream decoder. Feed the stream as big-endian 64-bit words starting
// right after the 8-byte file header, with first_word set on the first word of
// each stream; write the sample total register (byte address 0) before the
// stream starts.
// Header, history, weight and padding words are taken one per cycle while the
// two-entry request queue has room. A slice word is decoded one sample at a time
// in a product stage, then the accumulate/saturate/weight-update stage of the
// 4-tap LMS loop, which waits while a result is still held unaccepted; the next
// request is fetched only after the slice word's last sample. A malformed frame
// header yields one result with format_error set, after which every word is
// dropped until first_word. No clearing pass runs after reset.
module qoa_mono_stream_decoder
    import qoa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Stream words
    input  wire logic [63:0]  stream_word,
    input  wire logic         first_word,
    input  wire logic         word_valid,
    output logic              word_ready,
    // Samples
    output logic signed [15:0] pcm_sample,
    output logic              last_of_slice,
    output logic              stream_end,
    output logic              format_error,
    output logic              sample_valid,
    input  wire logic         sample_ready,
    // Configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0] sample_total_reg;
    logic        cfg_wr;

    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_full;
    logic cmd_pop;
    cmd_t cmd_out;
    logic cmd_empty;

    // Register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? '0 : sample_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_total_reg <= '0;
        end
        else if (cfg_wr)
        begin
            sample_total_reg <= pwdata;
        end
    end

    qoa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .stream_word   (stream_word),
        .first_word    (first_word),
        .word_valid    (word_valid),
        .word_ready    (word_ready),
        .sample_total  (sample_total_reg),
        .cmd_full      (cmd_full),
        .cmd_push      (cmd_push),
        .cmd_data      (cmd_in)
    );

    qoa_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd_in),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .pop_cmd  (cmd_out),
        .empty    (cmd_empty)
    );

    qoa_lms_engine u_lms_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_empty     (cmd_empty),
        .cmd_data      (cmd_out),
        .cmd_pop       (cmd_pop),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .pcm_sample    (pcm_sample),
        .last_of_slice (last_of_slice),
        .stream_end    (stream_end),
        .format_error  (format_error)
    );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;

    import qoa_pkg::*;

    localparam int          CYCLE_LIMIT        = 1000000;
    localparam int          DRAIN_CYCLES       = 100;
    localparam int          RANDOM_WORDS       = 360;
    localparam int          MAX_SLICE_WORDS    = 8;
    localparam logic [2:0]  SAMPLE_TOTAL_ADDR  = 3'd0;

    // Bit-accurate model of the decoder plus the queue of samples it owes
    class sample_scoreboard;

        typedef enum {
            AWAIT_HEADER,
            AWAIT_HISTORY,
            AWAIT_WEIGHTS,
            IN_SLICES,
            IN_PADDING,
            HALTED
        } decode_phase_t;

        typedef struct packed {
            logic signed [15:0] pcm;
            logic               last;
            logic               send;
            logic               err;
        } sample_t;

        bit [15:0]          dq_mag [16][4];
        bit [31:0]          total_cfg;
        decode_phase_t      phase;
        logic signed [15:0] hist [4];
        logic [15:0]        wgt [4];
        int unsigned        frame_left;
        int unsigned        bytes_left;
        bit [31:0]          stream_left;
        sample_t            expected_samples [$];
        int                 fails;

        function new();
            dq_mag[0]  = '{16'd1,    16'd3,    16'd5,    16'd7};
            dq_mag[1]  = '{16'd5,    16'd18,   16'd32,   16'd49};
            dq_mag[2]  = '{16'd16,   16'd53,   16'd95,   16'd147};
            dq_mag[3]  = '{16'd34,   16'd113,  16'd203,  16'd315};
            dq_mag[4]  = '{16'd63,   16'd210,  16'd378,  16'd588};
            dq_mag[5]  = '{16'd104,  16'd345,  16'd621,  16'd966};
            dq_mag[6]  = '{16'd158,  16'd528,  16'd950,  16'd1477};
            dq_mag[7]  = '{16'd228,  16'd760,  16'd1368, 16'd2128};
            dq_mag[8]  = '{16'd316,  16'd1053, 16'd1895, 16'd2947};
            dq_mag[9]  = '{16'd422,  16'd1405, 16'd2529, 16'd3934};
            dq_mag[10] = '{16'd548,  16'd1828, 16'd3290, 16'd5117};
            dq_mag[11] = '{16'd696,  16'd2320, 16'd4176, 16'd6496};
            dq_mag[12] = '{16'd868,  16'd2893, 16'd5207, 16'd8099};
            dq_mag[13] = '{16'd1064, 16'd3548, 16'd6386, 16'd9933};
            dq_mag[14] = '{16'd1286, 16'd4288, 16'd7718, 16'd12005};
            dq_mag[15] = '{16'd1536, 16'd5120, 16'd9216, 16'd14336};
            total_cfg   = '0;
            phase       = AWAIT_HEADER;
            frame_left  = 0;
            bytes_left  = 0;
            stream_left = '0;
            fails       = 0;
            for (int k = 0; k < 4; k++)
            begin
                hist[k] = '0;
                wgt[k]  = '0;
            end
        endfunction

        // Count one word against the frame size, stopping at zero
        function void drain_bytes();
            bytes_left = (bytes_left > 8) ? bytes_left - 8 : 0;
        endfunction

        // Advance the decoder by one accepted word request
        function void take_word(logic [63:0] w, logic restart);
            int unsigned fs;
            int unsigned fz;
            int unsigned n;
            longint      acc;
            int          pred;
            int          resid;
            int          smp;
            int          step;
            logic [2:0]  code;
            sample_t     res;

            if (restart)
            begin
                phase       = AWAIT_HEADER;
                frame_left  = 0;
                bytes_left  = 0;
                stream_left = total_cfg;
                for (int k = 0; k < 4; k++)
                begin
                    hist[k] = '0;
                    wgt[k]  = '0;
                end
            end
            if (phase == HALTED || stream_left == 0)
                return;

            case (phase)
                AWAIT_HEADER:
                begin
                    fs = w[31:16];
                    fz = w[15:0];
                    if (w[63:56] != 8'd1 || fs == 0 || fz < 24)
                    begin
                        phase = HALTED;
                        res = '{pcm: 16'sd0, last: 1'b1, send: 1'b0, err: 1'b1};
                        expected_samples.push_back(res);
                    end
                    else
                    begin
                        if (fs > stream_left)
                            fs = stream_left;
                        frame_left = fs;
                        bytes_left = fz - 8;
                        phase      = AWAIT_HISTORY;
                    end
                end
                AWAIT_HISTORY:
                begin
                    for (int k = 0; k < 4; k++)
                        hist[k] = w[48 - 16 * k +: 16];
                    drain_bytes();
                    phase = AWAIT_WEIGHTS;
                end
                AWAIT_WEIGHTS:
                begin
                    for (int k = 0; k < 4; k++)
                        wgt[k] = w[48 - 16 * k +: 16];
                    drain_bytes();
                    phase = IN_SLICES;
                end
                IN_PADDING:
                begin
                    drain_bytes();
                    if (bytes_left == 0)
                        phase = AWAIT_HEADER;
                end
                default:
                begin
                    n = (frame_left < SAMPLES_PER_SLICE) ? frame_left : SAMPLES_PER_SLICE;
                    drain_bytes();
                    for (int i = 0; i < n; i++)
                    begin
                        // 4-tap prediction, floor division by 2^13
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc += longint'($signed(wgt[k])) * longint'(hist[k]);
                        pred  = int'(acc >>> 13);
                        code  = w[57 - 3 * i +: 3];
                        resid = code[0] ? -int'(dq_mag[w[63:60]][code[2:1]])
                                        : int'(dq_mag[w[63:60]][code[2:1]]);
                        smp = pred + resid;
                        if (smp > 32767)
                            smp = 32767;
                        if (smp < -32768)
                            smp = -32768;
                        // Sign-LMS weight update, wrapping at 16 bits
                        step = resid >>> 4;
                        for (int k = 0; k < 4; k++)
                        begin
                            if (hist[k][15])
                                wgt[k] = wgt[k] - step[15:0];
                            else
                                wgt[k] = wgt[k] + step[15:0];
                        end
                        hist[0] = hist[1];
                        hist[1] = hist[2];
                        hist[2] = hist[3];
                        hist[3] = smp[15:0];
                        stream_left = stream_left - 1;
                        res = '{pcm: smp[15:0], last: (i == n - 1),
                                send: (stream_left == 0), err: 1'b0};
                        expected_samples.push_back(res);
                    end
                    frame_left = frame_left - n;
                    if (frame_left == 0)
                        phase = (bytes_left > 0) ? IN_PADDING : AWAIT_HEADER;
                end
            endcase
        endfunction

        function void compare_field(string field, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, field, want, got);
                fails++;
            end
        endfunction

        // Match one sample request against the oldest expectation
        function void check_sample(logic signed [15:0] pcm, logic last, logic send,
                                   logic err);
            sample_t want;
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, %s%0d last=%0b end=%0b err=%0b",
                         $time, "got pcm=", pcm, last, send, err);
                fails++;
                return;
            end
            want = expected_samples.pop_front();
            compare_field("pcm_sample", want.pcm, pcm);
            compare_field("last_of_slice", want.last, last);
            compare_field("stream_end", want.send, send);
            compare_field("format_error", want.err, err);
        endfunction

    endclass

    logic               clk;
    logic               rst_n;
    logic [63:0]        stream_word;
    logic               first_word;
    logic               word_valid;
    logic               word_ready;
    logic signed [15:0] pcm_sample;
    logic               last_of_slice;
    logic               stream_end;
    logic               format_error;
    logic               sample_valid;
    logic               sample_ready;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    sample_scoreboard board;
    bit               word_calm;
    int               work_words;

    qoa_mono_stream_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .stream_word   (stream_word),
        .first_word    (first_word),
        .word_valid    (word_valid),
        .word_ready    (word_ready),
        .pcm_sample    (pcm_sample),
        .last_of_slice (last_of_slice),
        .stream_end    (stream_end),
        .format_error  (format_error),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    // Four int16 lanes, either full range or within +-span
    function automatic logic [63:0] lane_word(bit wide, int span);
        logic [63:0] w;
        for (int k = 0; k < 4; k++)
        begin
            if (wide)
                w[48 - 16 * k +: 16] = 16'($urandom);
            else
                w[48 - 16 * k +: 16] = 16'(int'($urandom_range(0, 2 * span)) - span);
        end
        return w;
    endfunction

    // Offer one word request and hold it until accepted
    task automatic push_word(input logic [63:0] w, input logic restart, input bit counted);
        int gap;
        gap = draw_gap(word_calm);
        if (gap > 0)
        begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_valid  <= 1'b1;
        stream_word <= w;
        first_word  <= restart;
        @(posedge clk);
        while (word_ready !== 1'b1)
            @(posedge clk);
        board.take_word(w, restart);
        if (counted)
            work_words++;
    endtask

    // Drop valid, drain all owed samples, then let trailing words finish
    task automatic settle();
        word_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SAMPLE_TOTAL_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.total_cfg = value;
    endtask

    // Sample side: accept results with random stalls
    initial
    begin
        int gap;
        bit calm;
        calm = 1'b0;
        sample_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            gap = draw_gap(calm);
            if (gap > 0)
            begin
                sample_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            sample_ready <= 1'b1;
            @(posedge clk);
            while (sample_valid !== 1'b1)
                @(posedge clk);
            board.check_sample(pcm_sample, last_of_slice, stream_end, format_error);
        end
    end

    // Watchdog
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout with %0d samples outstanding", $time,
                 board.expected_samples.size());
        $display("FAILURE");
        $finish;
    end

    // Stream stimulus
    initial
    begin
        logic [31:0] total;
        longint      gen_left;
        int unsigned fs;
        int unsigned eff;
        int unsigned slices;
        int unsigned exact;
        int unsigned fz;
        int unsigned pad;
        int unsigned frames;
        bit          restart;
        bit          cut;
        bit          bad;
        logic [7:0]  ch;
        logic [15:0] bad_fs;
        logic [15:0] bad_fz;

        board = new();
        rst_n       <= 1'b0;
        stream_word <= '0;
        first_word  <= 1'b0;
        word_valid  <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        word_calm   = 1'b0;
        work_words  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Nothing decodes before the sample total is set
        push_word({8'd1, 24'd44100, 16'd20, 16'd32}, 1'b1, 1'b1);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);

        // Single-sample stream: header count capped, extreme history and weights
        settle();
        write_total(32'd1);
        push_word({8'd1, 24'hFFFFFF, 16'd5, 16'd24}, 1'b1, 1'b1);
        push_word(64'h7FFF_8000_0000_FFFF, 1'b0, 1'b1);
        push_word(64'h8000_7FFF_8000_7FFF, 1'b0, 1'b1);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
        push_word(64'h0000_0000_0000_0000, 1'b0, 1'b1);

        // Malformed headers, each with a restart; a valid header without one is dropped
        settle();
        write_total(32'hFFFF_FFFF);
        push_word({8'd0, 24'd0, 16'd20, 16'd24}, 1'b1, 1'b1);
        push_word({8'd1, 24'd0, 16'd20, 16'd24}, 1'b0, 1'b1);
        push_word({8'hFF, 24'd0, 16'd20, 16'd24}, 1'b1, 1'b1);
        push_word({8'd1, 24'd0, 16'd0, 16'd24}, 1'b1, 1'b1);
        push_word({8'd1, 24'd0, 16'd20, 16'd23}, 1'b1, 1'b1);

        // Largest header fields, saturating prediction, then restart mid-frame
        push_word({8'd1, 24'hFFFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b1);
        push_word(64'h8000_8000_7FFF_7FFF, 1'b0, 1'b1);
        push_word(64'h7FFF_7FFF_8000_8000, 1'b0, 1'b1);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
        push_word(64'h0000_0000_0000_0000, 1'b0, 1'b1);
        push_word(64'h0123_4567_89AB_CDEF, 1'b0, 1'b1);

        // Partial last slice, odd frame size with one padding word
        push_word({8'd1, 24'd48000, 16'd21, 16'd45}, 1'b1, 1'b1);
        push_word(64'h0000_0000_0000_0000, 1'b0, 1'b1);
        push_word({16'd0, 16'd0, 16'hE000, 16'h4000}, 1'b0, 1'b1);
        push_word({$urandom, $urandom}, 1'b0, 1'b1);
        push_word({$urandom, $urandom}, 1'b0, 1'b1);
        push_word({$urandom, $urandom}, 1'b0, 1'b1);

        // Random streams of well-formed frames with some broken headers
        work_words = 0;
        while (work_words < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0:       total = 32'd0;
                1:       total = 32'hFFFF_FFFF;
                2:       total = $urandom;
                default: total = $urandom_range(1, 300);
            endcase
            settle();
            write_total(total);
            word_calm = ($urandom_range(0, 3) == 0);
            gen_left  = total;
            restart   = 1'b1;
            frames    = 0;
            cut       = 1'b0;
            bad       = 1'b0;

            // A zero total leaves the stream exhausted from the first word
            if (total == 0)
                push_word({$urandom, $urandom}, 1'b1, 1'b0);

            while (gen_left > 0 && frames < 6 && !cut && !bad)
            begin
                if (frames > 0 && $urandom_range(0, 15) == 0)
                begin
                    restart  = 1'b1;
                    gen_left = total;
                end
                if ($urandom_range(0, 11) == 0)
                begin
                    ch     = 8'd1;
                    bad_fs = 16'($urandom_range(1, 400));
                    bad_fz = 16'($urandom_range(24, 2000));
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            ch = 8'($urandom);
                            if (ch == 8'd1)
                                ch = 8'd0;
                        end
                        1:       bad_fs = 16'd0;
                        default: bad_fz = 16'($urandom_range(0, 23));
                    endcase
                    push_word({ch, 24'($urandom), bad_fs, bad_fz}, restart, 1'b1);
                    bad = 1'b1;
                end
                else
                begin
                    case ($urandom_range(0, 5))
                        0:       fs = 20 * $urandom_range(1, 4);
                        1:       fs = $urandom_range(1, 19);
                        2:       fs = 16'hFFFF;
                        default: fs = $urandom_range(1, 100);
                    endcase
                    eff    = (fs > gen_left) ? int'(gen_left) : fs;
                    slices = (eff + SAMPLES_PER_SLICE - 1) / SAMPLES_PER_SLICE;
                    exact  = MIN_FRAME + WORD_BYTES * slices;
                    case ($urandom_range(0, 3))
                        0:       fz = $urandom_range(MIN_FRAME, exact);
                        1:       fz = exact + $urandom_range(1, 47);
                        default: fz = exact;
                    endcase
                    pad = (fz > exact) ? (fz - exact + WORD_BYTES - 1) / WORD_BYTES : 0;
                    cut = (slices > MAX_SLICE_WORDS);

                    push_word({8'd1, 24'($urandom), 16'(fs), 16'(fz)}, restart, 1'b1);
                    push_word(lane_word(1'($urandom_range(0, 1)), 2000), 1'b0, 1'b1);
                    case ($urandom_range(0, 2))
                        0:       push_word({16'd0, 16'd0, 16'hE000, 16'h4000}, 1'b0, 1'b1);
                        1:       push_word(lane_word(1'b1, 0), 1'b0, 1'b1);
                        default: push_word(lane_word(1'b0, 16384), 1'b0, 1'b1);
                    endcase
                    repeat (cut ? MAX_SLICE_WORDS : slices)
                        push_word({$urandom, $urandom}, 1'b0, 1'b1);
                    if (!cut)
                    begin
                        repeat (pad) push_word({$urandom, $urandom}, 1'b0, 1'b0);
                        gen_left = gen_left - eff;
                    end
                end
                restart = 1'b0;
                frames++;
            end

            // Words past the end of the stream or after an error are dropped
            if (gen_left == 0 || bad)
                repeat ($urandom_range(0, 2)) push_word({$urandom, $urandom}, 1'b0, 1'b0);
        end

        settle();
        if (board.fails == 0 && board.expected_samples.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
